### src/assert_macros.svh
// Assertion macros shared by the touch sample mapper.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/tsm_pkg.sv
// Package for the touch sample mapper: field widths, register codes,
// reset values and the command and status types between controller and datapath.
// Depends on nothing.
package tsm_pkg;

	localparam int RAW_W      = 12;
	localparam int PRES_W     = 13;
	localparam int DEB_W      = 16;
	localparam int SIZE_W     = 11;
	localparam int COORD_W    = 10;
	localparam int TIME_W     = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int DIVIDEND_W = 24;
	localparam int DIVISOR_W  = RAW_W;
	localparam int DIV_STEPS  = 2;

	localparam logic [PRES_W-1:0]  PRESSURE_CEIL = PRES_W'(5000);
	localparam logic [COORD_W-1:0] COORD_MAX     = COORD_W'(1023);
	localparam logic [SIZE_W-1:0]  SIZE_SAT      = SIZE_W'(1024);

	localparam logic [CFG_IDX_W-1:0] REG_RAW_Y_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_Y_HIGH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_X_LOW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAW_X_HIGH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESSURE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DISP_WIDTH    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DISP_HEIGHT   = 3'd7;

	localparam logic [RAW_W-1:0]  RST_RAW_Y_LOW     = RAW_W'(500);
	localparam logic [RAW_W-1:0]  RST_RAW_Y_HIGH    = RAW_W'(3600);
	localparam logic [RAW_W-1:0]  RST_RAW_X_LOW     = RAW_W'(600);
	localparam logic [RAW_W-1:0]  RST_RAW_X_HIGH    = RAW_W'(3600);
	localparam logic [PRES_W-1:0] RST_MIN_PRESSURE  = PRES_W'(200);
	localparam logic [DEB_W-1:0]  RST_DEBOUNCE_MS   = DEB_W'(50);
	localparam logic [SIZE_W-1:0] RST_DISP_WIDTH    = SIZE_W'(320);
	localparam logic [SIZE_W-1:0] RST_DISP_HEIGHT   = SIZE_W'(240);

	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	typedef struct packed {
		logic [RAW_W-1:0]  raw_y_low;
		logic [RAW_W-1:0]  raw_y_high;
		logic [RAW_W-1:0]  raw_x_low;
		logic [RAW_W-1:0]  raw_x_high;
		logic [PRES_W-1:0] min_pressure;
		logic [DEB_W-1:0]  debounce_ms;
		logic [SIZE_W-1:0] disp_width;
		logic [SIZE_W-1:0] disp_height;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic mul_load;
		logic div_start;
		logic store;
		logic commit;
		logic axis;
	} cmd_t;

	typedef struct packed {
		logic press;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

### src/touch_sample_map_and_tap_detect_top.sv
// Touch sample mapper with tap detection, top level.
// Input channel: one panel sample per transaction (contact, raw_x, raw_y,
// raw_pressure, now_ms), accepted when in_valid is high and in_stall is low.
// Output channel: one result per sample, presented with out_valid and held
// while out_stall is high; the output register lets the block take the next
// sample while a result still waits.
// Samples are handled one at a time: a new sample is taken only after
// the state update of the last one. A sample that is not a press goes from
// capture through evaluation to the state update. A press goes first to the
// shared divider, which scales screen x and then screen y, each in
// 12 iterations of two quotient bits after its operands are loaded, and
// each scaled coordinate is stored before the state update.
// If the previous result is still stalled, the state update waits for it.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wr_data.
// The user must write it only while the block is idle; it is not enforced.
// Reset loads the default calibration, clears the current point and the
// saved tap, and empties the output register.
// Depends on tsm_pkg, tsm_ctrl, tsm_dp, tsm_div and assert_macros.svh.
`include "assert_macros.svh"

module touch_sample_map_and_tap_detect_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [tsm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsm_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             contact,
	input  logic [tsm_pkg::RAW_W-1:0]       raw_x,
	input  logic [tsm_pkg::RAW_W-1:0]       raw_y,
	input  logic [tsm_pkg::PRES_W-1:0]      raw_pressure,
	input  logic [tsm_pkg::TIME_W-1:0]      now_ms,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tsm_pkg::COORD_W-1:0]     point_x,
	output logic [tsm_pkg::COORD_W-1:0]     point_y,
	output logic [tsm_pkg::PRES_W-1:0]      point_pressure,
	output logic                             pressed,
	output logic                             tapped,
	output logic [tsm_pkg::COORD_W-1:0]     tap_x,
	output logic [tsm_pkg::COORD_W-1:0]     tap_y,
	output logic [tsm_pkg::PRES_W-1:0]      tap_pressure,
	output logic                             tap_valid
);
	import tsm_pkg::*;

	cmd_t    cmd;
	status_t status;

	tsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	tsm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wr_data    (cfg_wr_data),
		.contact        (contact),
		.raw_x          (raw_x),
		.raw_y          (raw_y),
		.raw_pressure   (raw_pressure),
		.now_ms         (now_ms),
		.out_stall      (out_stall),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (out_valid),
		.point_x        (point_x),
		.point_y        (point_y),
		.point_pressure (point_pressure),
		.pressed        (pressed),
		.tapped         (tapped),
		.tap_x          (tap_x),
		.tap_y          (tap_y),
		.tap_pressure   (tap_pressure),
		.tap_valid      (tap_valid)
	);

	`ASSERT_IMPL(a_tap_recorded, out_valid && tapped, tap_valid && !pressed, "tap without record")
	`ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second sample taken early")
	`ASSERT_IMPL(a_store_after_div, cmd.store, status.div_done, "coordinate stored early")
	`ASSERT_IMPL(a_commit_free, cmd.commit, status.out_free, "result overwrote pending one")

endmodule

### src/tsm_div.sv
// Iterative unsigned restoring divider, two quotient bits per cycle.
// Depends on tsm_pkg for the operand widths.
module tsm_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [tsm_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [tsm_pkg::DIVISOR_W-1:0]  divisor,
	output logic [tsm_pkg::DIVIDEND_W-1:0] quotient,
	output logic                            done
);
	import tsm_pkg::*;

	localparam int ITERS = DIVIDEND_W / DIV_STEPS;
	localparam int CNT_W = $clog2(ITERS);

	logic [DIVIDEND_W-1:0] work_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvsr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVIDEND_W-1:0] work_d;
	logic [DIVISOR_W-1:0]  rem_d;

	function automatic logic [DIVISOR_W:0] div_step(
		input logic [DIVISOR_W-1:0] rem,
		input logic                 bit_in,
		input logic [DIVISOR_W-1:0] dvsr
	);
		logic [DIVISOR_W:0]   shifted;
		logic [DIVISOR_W+1:0] trial;
		shifted = {rem, bit_in};
		trial   = {1'b0, shifted} - {2'b00, dvsr};
		if (trial[DIVISOR_W+1]) begin
			div_step = {shifted[DIVISOR_W-1:0], 1'b0};
		end else begin
			div_step = {trial[DIVISOR_W-1:0], 1'b1};
		end
	endfunction

	always_comb begin
		logic [DIVISOR_W:0] res;
		work_d = work_q;
		rem_d  = rem_q;
		for (int i = 0; i < DIV_STEPS; i++) begin
			res    = div_step(rem_d, work_d[DIVIDEND_W-1], dvsr_q);
			rem_d  = res[DIVISOR_W:1];
			work_d = {work_d[DIVIDEND_W-2:0], res[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	assign quotient = work_q;
	assign done     = done_q;

endmodule

### src/tsm_dp.sv
// Datapath of the touch sample mapper: configuration registers, sample capture,
// axis scaling with the shared divider, tap state and the output register.
// Depends on tsm_pkg and tsm_div.
module tsm_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [tsm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsm_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
	input  logic                             contact,
	input  logic [tsm_pkg::RAW_W-1:0]       raw_x,
	input  logic [tsm_pkg::RAW_W-1:0]       raw_y,
	input  logic [tsm_pkg::PRES_W-1:0]      raw_pressure,
	input  logic [tsm_pkg::TIME_W-1:0]      now_ms,
	input  logic                             out_stall,
	input  tsm_pkg::cmd_t                    cmd,
	output tsm_pkg::status_t                 status,
	output logic                             out_valid,
	output logic [tsm_pkg::COORD_W-1:0]     point_x,
	output logic [tsm_pkg::COORD_W-1:0]     point_y,
	output logic [tsm_pkg::PRES_W-1:0]      point_pressure,
	output logic                             pressed,
	output logic                             tapped,
	output logic [tsm_pkg::COORD_W-1:0]     tap_x,
	output logic [tsm_pkg::COORD_W-1:0]     tap_y,
	output logic [tsm_pkg::PRES_W-1:0]      tap_pressure,
	output logic                             tap_valid
);
	import tsm_pkg::*;

	cfg_t cfg_q;

	logic              smp_contact_q;
	logic [RAW_W-1:0]  smp_raw_x_q;
	logic [RAW_W-1:0]  smp_raw_y_q;
	logic [PRES_W-1:0] smp_pres_q;
	logic [TIME_W-1:0] smp_now_q;

	logic [DIVIDEND_W-1:0] dividend_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic                  zero_out_q;
	logic [COORD_W-1:0]    lim_q;

	logic [COORD_W-1:0] cur_x_q;
	logic [COORD_W-1:0] cur_y_q;
	logic [PRES_W-1:0]  cur_pres_q;
	logic               cur_valid_q;
	logic [TIME_W-1:0]  last_tap_q;
	logic [COORD_W-1:0] saved_x_q;
	logic [COORD_W-1:0] saved_y_q;
	logic [PRES_W-1:0]  saved_pres_q;
	logic               saved_valid_q;
	logic               out_valid_q;

	logic [RAW_W-1:0]      raw_sel;
	logic [RAW_W-1:0]      lo_sel;
	logic [RAW_W-1:0]      hi_sel;
	logic [SIZE_W-1:0]     size_sel;
	logic [RAW_W:0]        diff;
	logic [RAW_W:0]        den;
	logic [RAW_W:0]        diff_neg;
	logic [RAW_W:0]        den_neg;
	logic [RAW_W-1:0]      diff_mag;
	logic [RAW_W-1:0]      den_mag;
	logic [RAW_W+SIZE_W-1:0] prod;
	logic [DIVIDEND_W-1:0] quotient;
	logic                  div_done;
	logic [COORD_W-1:0]    coord;
	logic                  press;
	logic [TIME_W-1:0]     elapsed;
	logic                  tap_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.raw_y_low     <= RST_RAW_Y_LOW;
			cfg_q.raw_y_high    <= RST_RAW_Y_HIGH;
			cfg_q.raw_x_low     <= RST_RAW_X_LOW;
			cfg_q.raw_x_high    <= RST_RAW_X_HIGH;
			cfg_q.min_pressure  <= RST_MIN_PRESSURE;
			cfg_q.debounce_ms   <= RST_DEBOUNCE_MS;
			cfg_q.disp_width    <= RST_DISP_WIDTH;
			cfg_q.disp_height   <= RST_DISP_HEIGHT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_RAW_Y_LOW:     cfg_q.raw_y_low     <= cfg_wr_data[RAW_W-1:0];
				REG_RAW_Y_HIGH:    cfg_q.raw_y_high    <= cfg_wr_data[RAW_W-1:0];
				REG_RAW_X_LOW:     cfg_q.raw_x_low     <= cfg_wr_data[RAW_W-1:0];
				REG_RAW_X_HIGH:    cfg_q.raw_x_high    <= cfg_wr_data[RAW_W-1:0];
				REG_MIN_PRESSURE:  cfg_q.min_pressure  <= cfg_wr_data[PRES_W-1:0];
				REG_DEBOUNCE_MS:   cfg_q.debounce_ms   <= cfg_wr_data[DEB_W-1:0];
				REG_DISP_WIDTH:    cfg_q.disp_width    <= cfg_wr_data[SIZE_W-1:0];
				REG_DISP_HEIGHT:   cfg_q.disp_height   <= cfg_wr_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smp_contact_q <= contact;
			smp_raw_x_q   <= raw_x;
			smp_raw_y_q   <= raw_y;
			smp_pres_q    <= raw_pressure;
			smp_now_q     <= now_ms;
		end
	end

	assign press = smp_contact_q && (smp_pres_q >= cfg_q.min_pressure)
		&& (smp_pres_q < PRESSURE_CEIL);

	// Screen x comes from raw y and screen y from raw x.
	always_comb begin
		if (cmd.axis == AXIS_Y) begin
			raw_sel  = smp_raw_x_q;
			lo_sel   = cfg_q.raw_x_low;
			hi_sel   = cfg_q.raw_x_high;
			size_sel = cfg_q.disp_height;
		end else begin
			raw_sel  = smp_raw_y_q;
			lo_sel   = cfg_q.raw_y_low;
			hi_sel   = cfg_q.raw_y_high;
			size_sel = cfg_q.disp_width;
		end
	end

	assign diff     = {1'b0, raw_sel} - {1'b0, lo_sel};
	assign den      = {1'b0, hi_sel} - {1'b0, lo_sel};
	assign diff_neg = -diff;
	assign den_neg  = -den;
	assign diff_mag = diff[RAW_W] ? diff_neg[RAW_W-1:0] : diff[RAW_W-1:0];
	assign den_mag  = den[RAW_W] ? den_neg[RAW_W-1:0] : den[RAW_W-1:0];
	assign prod     = {{SIZE_W{1'b0}}, diff_mag} * {{RAW_W{1'b0}}, size_sel};

	// A quotient of opposite signs is never positive, so it clamps to zero.
	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			dividend_q <= DIVIDEND_W'(prod);
			divisor_q  <= den_mag;
			zero_out_q <= (den == '0) || (size_sel == '0) || (diff[RAW_W] != den[RAW_W]);
			lim_q      <= (size_sel > SIZE_SAT) ? COORD_MAX : COORD_W'(size_sel - SIZE_W'(1));
		end
	end

	tsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend_q),
		.divisor  (divisor_q),
		.quotient (quotient),
		.done     (div_done)
	);

	always_comb begin
		if (zero_out_q) begin
			coord = '0;
		end else if (quotient > DIVIDEND_W'(lim_q)) begin
			coord = lim_q;
		end else begin
			coord = quotient[COORD_W-1:0];
		end
	end

	assign elapsed  = smp_now_q - last_tap_q;
	assign tap_fire = !smp_contact_q && cur_valid_q && (elapsed > TIME_W'(cfg_q.debounce_ms));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			cur_pres_q    <= '0;
			cur_valid_q   <= 1'b0;
			last_tap_q    <= '0;
			saved_x_q     <= '0;
			saved_y_q     <= '0;
			saved_pres_q  <= '0;
			saved_valid_q <= 1'b0;
		end else begin
			if (cmd.store) begin
				if (cmd.axis == AXIS_Y) begin
					cur_y_q <= coord;
				end else begin
					cur_x_q <= coord;
				end
			end
			if (cmd.commit) begin
				cur_valid_q <= press;
				if (press) begin
					cur_pres_q <= smp_pres_q;
				end
				if (tap_fire) begin
					saved_x_q     <= cur_x_q;
					saved_y_q     <= cur_y_q;
					saved_pres_q  <= cur_pres_q;
					saved_valid_q <= 1'b1;
					last_tap_q    <= smp_now_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			point_x        <= cur_x_q;
			point_y        <= cur_y_q;
			point_pressure <= press ? smp_pres_q : cur_pres_q;
			pressed        <= press;
			tapped         <= tap_fire;
			tap_x          <= tap_fire ? cur_x_q : saved_x_q;
			tap_y          <= tap_fire ? cur_y_q : saved_y_q;
			tap_pressure   <= tap_fire ? cur_pres_q : saved_pres_q;
			tap_valid      <= tap_fire || saved_valid_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.press    = press;
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || !out_stall;

endmodule

### src/tsm_ctrl.sv
// Controller of the touch sample mapper: sequences capture, the two axis
// scalings for a press and the final state update. Depends on tsm_pkg.
module tsm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  tsm_pkg::status_t status,
	output tsm_pkg::cmd_t    cmd
);
	import tsm_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EVAL   = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_DSTART = 3'd3;
	localparam logic [2:0] S_DWAIT  = 3'd4;
	localparam logic [2:0] S_COMMIT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       axis_q;
	logic       axis_d;

	always_comb begin
		state_d       = state_q;
		axis_d        = axis_q;
		cmd           = '0;
		cmd.axis      = axis_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				axis_d  = AXIS_X;
				state_d = status.press ? S_MUL : S_COMMIT;
			end
			S_MUL: begin
				cmd.mul_load = 1'b1;
				state_d      = S_DSTART;
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_DWAIT;
			end
			S_DWAIT: begin
				if (status.div_done) begin
					cmd.store = 1'b1;
					if (axis_q == AXIS_X) begin
						axis_d  = AXIS_Y;
						state_d = S_MUL;
					end else begin
						state_d = S_COMMIT;
					end
				end
			end
			S_COMMIT: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= AXIS_X;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for touch_sample_map_and_tap_detect_top: sends panel samples
// and calibration writes, predicts every result in its own model and checks each output.
// Depends on tsm_pkg and the top level of the block.
module tb_top;
	import tsm_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int END_WAIT       = 40;

	typedef struct packed {
		logic              contact;
		logic [RAW_W-1:0]  raw_x;
		logic [RAW_W-1:0]  raw_y;
		logic [PRES_W-1:0] raw_pressure;
		logic [TIME_W-1:0] now_ms;
	} touch_sample_t;

	typedef struct packed {
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
		logic [PRES_W-1:0]  point_pressure;
		logic               pressed;
		logic               tapped;
		logic [COORD_W-1:0] tap_x;
		logic [COORD_W-1:0] tap_y;
		logic [PRES_W-1:0]  tap_pressure;
		logic               tap_valid;
	} touch_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wr_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  contact;
	logic [RAW_W-1:0]      raw_x;
	logic [RAW_W-1:0]      raw_y;
	logic [PRES_W-1:0]     raw_pressure;
	logic [TIME_W-1:0]     now_ms;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [COORD_W-1:0]    point_x;
	logic [COORD_W-1:0]    point_y;
	logic [PRES_W-1:0]     point_pressure;
	logic                  pressed;
	logic                  tapped;
	logic [COORD_W-1:0]    tap_x;
	logic [COORD_W-1:0]    tap_y;
	logic [PRES_W-1:0]     tap_pressure;
	logic                  tap_valid;

	cfg_t               cal;
	logic               was_down;
	logic [TIME_W-1:0]  last_tap_ms;
	logic [COORD_W-1:0] hold_x;
	logic [COORD_W-1:0] hold_y;
	logic [PRES_W-1:0]  hold_p;
	logic               hold_valid;
	logic [COORD_W-1:0] saved_x;
	logic [COORD_W-1:0] saved_y;
	logic [PRES_W-1:0]  saved_p;
	logic               tap_seen;

	touch_result_t expected_results[$];
	touch_result_t want_res;
	touch_result_t got_res;
	int            mismatches = 0;
	int            idle_cycles = 0;
	int            stall_left = 0;
	bit            gaps_on;
	logic [TIME_W-1:0] clock_ms;

	touch_sample_map_and_tap_detect_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.contact(contact),
		.raw_x(raw_x),
		.raw_y(raw_y),
		.raw_pressure(raw_pressure),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.point_x(point_x),
		.point_y(point_y),
		.point_pressure(point_pressure),
		.pressed(pressed),
		.tapped(tapped),
		.tap_x(tap_x),
		.tap_y(tap_y),
		.tap_pressure(tap_pressure),
		.tap_valid(tap_valid)
	);

	always #5 clk = ~clk;

	function automatic logic [COORD_W-1:0] scale_axis(input logic [RAW_W-1:0] raw,
		input logic [RAW_W-1:0] lo, input logic [RAW_W-1:0] hi, input logic [SIZE_W-1:0] size);
		int num;
		int den;
		int q;
		int lim;
		num = (int'(raw) - int'(lo)) * int'(size);
		den = int'(hi) - int'(lo);
		q = (den == 0) ? 0 : num / den;
		if (size == '0) begin
			return '0;
		end
		lim = int'(size) - 1;
		if (lim > int'(COORD_MAX)) begin
			lim = int'(COORD_MAX);
		end
		if (q < 0) begin
			q = 0;
		end
		if (q > lim) begin
			q = lim;
		end
		return COORD_W'(q);
	endfunction

	function automatic touch_result_t predict_result(input touch_sample_t s);
		touch_result_t r;
		logic [TIME_W-1:0] since_tap;
		since_tap = s.now_ms - last_tap_ms;
		r.tapped = 1'b0;
		if (!s.contact) begin
			if (was_down && since_tap > TIME_W'(cal.debounce_ms)) begin
				r.tapped = 1'b1;
				saved_x = hold_x;
				saved_y = hold_y;
				saved_p = hold_p;
				tap_seen = hold_valid;
				last_tap_ms = s.now_ms;
			end
			hold_valid = 1'b0;
			was_down = 1'b0;
		end else if (s.raw_pressure >= cal.min_pressure && s.raw_pressure < PRESSURE_CEIL) begin
			hold_x = scale_axis(s.raw_y, cal.raw_y_low, cal.raw_y_high, cal.disp_width);
			hold_y = scale_axis(s.raw_x, cal.raw_x_low, cal.raw_x_high, cal.disp_height);
			hold_p = s.raw_pressure;
			hold_valid = 1'b1;
			was_down = 1'b1;
		end else begin
			hold_valid = 1'b0;
			was_down = 1'b0;
		end
		r.point_x = hold_x;
		r.point_y = hold_y;
		r.point_pressure = hold_p;
		r.pressed = hold_valid;
		r.tap_x = saved_x;
		r.tap_y = saved_y;
		r.tap_pressure = saved_p;
		r.tap_valid = tap_seen;
		return r;
	endfunction

	function automatic touch_sample_t make_sample(input logic c, input logic [RAW_W-1:0] rx,
		input logic [RAW_W-1:0] ry, input logic [PRES_W-1:0] p, input logic [TIME_W-1:0] t);
		touch_sample_t s;
		s.contact = c;
		s.raw_x = rx;
		s.raw_y = ry;
		s.raw_pressure = p;
		s.now_ms = t;
		return s;
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw(input logic [RAW_W-1:0] lo,
		input logic [RAW_W-1:0] hi);
		case ($urandom_range(0, 7))
			0: return lo;
			1: return hi;
			2: return '0;
			3: return '1;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	task automatic show_mismatch(input string what, input touch_result_t want,
		input touch_result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s: expected pt=(%0d,%0d,%0d) pressed=%0b tapped=%0b tap=(%0d,%0d,%0d) tv=%0b",
				what, want.point_x, want.point_y, want.point_pressure, want.pressed,
				want.tapped, want.tap_x, want.tap_y, want.tap_pressure, want.tap_valid);
			$display("%s: actual   pt=(%0d,%0d,%0d) pressed=%0b tapped=%0b tap=(%0d,%0d,%0d) tv=%0b",
				what, got.point_x, got.point_y, got.point_pressure, got.pressed,
				got.tapped, got.tap_x, got.tap_y, got.tap_pressure, got.tap_valid);
		end
	endtask

	task automatic send_sample(input touch_sample_t s);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		contact <= s.contact;
		raw_x <= s.raw_x;
		raw_y <= s.raw_y;
		raw_pressure <= s.raw_pressure;
		now_ms <= s.now_ms;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_results.push_back(predict_result(s));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
		input int width);
		logic [CFG_DATA_W-1:0] mask;
		logic [CFG_DATA_W-1:0] data;
		mask = (CFG_DATA_W'(1) << width) - CFG_DATA_W'(1);
		data = CFG_DATA_W'($urandom);
		data = (data & ~mask) | (value & mask);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= data;
		@(posedge clk);
	endtask

	task automatic load_calibration(input cfg_t c);
		write_reg(REG_RAW_Y_LOW, CFG_DATA_W'(c.raw_y_low), RAW_W);
		write_reg(REG_RAW_Y_HIGH, CFG_DATA_W'(c.raw_y_high), RAW_W);
		write_reg(REG_RAW_X_LOW, CFG_DATA_W'(c.raw_x_low), RAW_W);
		write_reg(REG_RAW_X_HIGH, CFG_DATA_W'(c.raw_x_high), RAW_W);
		write_reg(REG_MIN_PRESSURE, CFG_DATA_W'(c.min_pressure), PRES_W);
		write_reg(REG_DEBOUNCE_MS, CFG_DATA_W'(c.debounce_ms), DEB_W);
		write_reg(REG_DISP_WIDTH, CFG_DATA_W'(c.disp_width), SIZE_W);
		write_reg(REG_DISP_HEIGHT, CFG_DATA_W'(c.disp_height), SIZE_W);
		cfg_wr_en <= 1'b0;
		cal = c;
	endtask

	task automatic test_default_mapping();
		send_sample(make_sample(1'b0, 12'd0, 12'd0, 13'd0, 32'd0));
		send_sample(make_sample(1'b1, 12'd600, 12'd500, 13'd200, 32'd10));
		send_sample(make_sample(1'b0, 12'd0, 12'd0, 13'd0, 32'd30));
		send_sample(make_sample(1'b1, 12'd4095, 12'd4095, 13'd4999, 32'd40));
		send_sample(make_sample(1'b0, 12'd4095, 12'd4095, 13'd8191, 32'd100));
		send_sample(make_sample(1'b1, 12'd3600, 12'd3600, 13'd1000, 32'd110));
		send_sample(make_sample(1'b0, 12'd0, 12'd0, 13'd0, 32'd150));
		send_sample(make_sample(1'b1, 12'd2000, 12'd2000, 13'd199, 32'd160));
		send_sample(make_sample(1'b1, 12'd2000, 12'd2000, 13'd5000, 32'd170));
		send_sample(make_sample(1'b1, 12'd0, 12'd0, 13'd300, 32'd180));
		send_sample(make_sample(1'b1, 12'd1000, 12'd1000, 13'd100, 32'd190));
		send_sample(make_sample(1'b0, 12'd0, 12'd0, 13'd0, 32'd300));
		send_sample(make_sample(1'b1, 12'd2000, 12'd2000, 13'd2500, 32'd310));
		send_sample(make_sample(1'b0, 12'd0, 12'd0, 13'd0, 32'd400));
		send_sample(make_sample(1'b1, 12'd1234, 12'd3210, 13'd4000, 32'hFFFF_FFF0));
		send_sample(make_sample(1'b0, 12'd0, 12'd0, 13'd0, 32'hFFFF_FFF8));
		send_sample(make_sample(1'b1, 12'd3210, 12'd1234, 13'd600, 32'hFFFF_FFFC));
		send_sample(make_sample(1'b0, 12'd0, 12'd0, 13'd0, 32'h0000_0020));
		send_sample(make_sample(1'b1, 12'd777, 12'd2222, 13'd700, 32'h0000_0030));
		send_sample(make_sample(1'b0, 12'd0, 12'd0, 13'd0, 32'h0000_0040));
	endtask

	task automatic test_calibration_edges();
		cfg_t c;
		c.raw_y_low = 12'd2000;
		c.raw_y_high = 12'd2000;
		c.raw_x_low = 12'd3600;
		c.raw_x_high = 12'd600;
		c.min_pressure = 13'd0;
		c.debounce_ms = 16'd0;
		c.disp_width = 11'd1024;
		c.disp_height = 11'd2047;
		wait_drained();
		load_calibration(c);
		send_sample(make_sample(1'b1, 12'd0, 12'd4095, 13'd0, 32'd1000));
		send_sample(make_sample(1'b1, 12'd3000, 12'd0, 13'd4999, 32'd1000));
		send_sample(make_sample(1'b0, 12'd0, 12'd0, 13'd0, 32'd1000));
		send_sample(make_sample(1'b1, 12'd4095, 12'd2000, 13'd1, 32'd1000));
		send_sample(make_sample(1'b0, 12'd0, 12'd0, 13'd0, 32'd1000));
		c.raw_y_low = 12'd0;
		c.raw_y_high = 12'd4095;
		c.raw_x_low = 12'd0;
		c.raw_x_high = 12'd4095;
		c.min_pressure = 13'd4999;
		c.debounce_ms = 16'hFFFF;
		c.disp_width = 11'd0;
		c.disp_height = 11'd1;
		wait_drained();
		load_calibration(c);
		send_sample(make_sample(1'b1, 12'd4095, 12'd4095, 13'd4999, 32'd2000));
		send_sample(make_sample(1'b0, 12'd0, 12'd0, 13'd0, 32'd2002));
	endtask

	task automatic run_gestures(input int count);
		int sent;
		int presses;
		touch_sample_t s;
		sent = 0;
		while (sent < count) begin
			case ($urandom_range(0, 9))
				7, 8: begin
					if ($urandom_range(0, 1) == 0) begin
						clock_ms = $urandom;
					end else begin
						clock_ms += $urandom_range(0, 50);
					end
					s = make_sample(1'($urandom), RAW_W'($urandom), RAW_W'($urandom),
						PRES_W'($urandom), clock_ms);
					send_sample(s);
					sent++;
				end
				9: begin
					clock_ms += $urandom_range(0, 200);
					s = make_sample(1'b0, RAW_W'($urandom), RAW_W'($urandom),
						PRES_W'($urandom), clock_ms);
					send_sample(s);
					sent++;
				end
				default: begin
					presses = $urandom_range(1, 4);
					repeat (presses) begin
						clock_ms += $urandom_range(0, 20);
						s = make_sample(1'b1, pick_raw(cal.raw_x_low, cal.raw_x_high),
							pick_raw(cal.raw_y_low, cal.raw_y_high), PRES_W'($urandom), clock_ms);
						if (cal.min_pressure < PRESSURE_CEIL) begin
							case ($urandom_range(0, 9))
								0: s.raw_pressure = cal.min_pressure;
								1: s.raw_pressure = PRES_W'(PRESSURE_CEIL - 1);
								2: begin
									if (cal.min_pressure != '0 && $urandom_range(0, 1) == 0) begin
										s.raw_pressure = PRES_W'($urandom_range(0,
											cal.min_pressure - 1));
									end else begin
										s.raw_pressure = PRES_W'($urandom_range(PRESSURE_CEIL,
											8191));
									end
								end
								default: s.raw_pressure = PRES_W'($urandom_range(
									cal.min_pressure, PRESSURE_CEIL - 1));
							endcase
						end
						send_sample(s);
						sent++;
					end
					case ($urandom_range(0, 3))
						0, 1: clock_ms = last_tap_ms + TIME_W'(cal.debounce_ms) +
							$urandom_range(1, 40);
						2: clock_ms = last_tap_ms + $urandom_range(0, cal.debounce_ms);
						default: clock_ms += $urandom_range(0, 100);
					endcase
					s = make_sample(1'b0, RAW_W'($urandom), RAW_W'($urandom),
						PRES_W'($urandom), clock_ms);
					send_sample(s);
					sent++;
				end
			endcase
		end
	endtask

	task automatic test_random_sessions();
		int kinds [10] = '{0, 1, 2, 3, 4, 5, 6, 1, 6, 0};
		int lengths [10] = '{200, 200, 150, 150, 120, 60, 200, 150, 150, 170};
		cfg_t c;
		for (int ph = 0; ph < 10; ph++) begin
			c.raw_y_low = RAW_W'($urandom_range(0, 1500));
			c.raw_y_high = RAW_W'($urandom_range(2500, 4095));
			c.raw_x_low = RAW_W'($urandom_range(0, 1500));
			c.raw_x_high = RAW_W'($urandom_range(2500, 4095));
			c.min_pressure = PRES_W'($urandom_range(0, 1000));
			c.debounce_ms = DEB_W'($urandom_range(0, 300));
			c.disp_width = SIZE_W'($urandom_range(1, 1024));
			c.disp_height = SIZE_W'($urandom_range(1, 1024));
			case (kinds[ph])
				0: begin
					c.raw_y_low = RST_RAW_Y_LOW;
					c.raw_y_high = RST_RAW_Y_HIGH;
					c.raw_x_low = RST_RAW_X_LOW;
					c.raw_x_high = RST_RAW_X_HIGH;
					c.min_pressure = RST_MIN_PRESSURE;
					c.debounce_ms = RST_DEBOUNCE_MS;
					c.disp_width = RST_DISP_WIDTH;
					c.disp_height = RST_DISP_HEIGHT;
				end
				2: begin
					c.raw_y_low = '0;
					c.raw_y_high = '1;
					c.raw_x_low = '0;
					c.raw_x_high = '1;
					c.min_pressure = '0;
					c.debounce_ms = '0;
					c.disp_width = SIZE_SAT;
					c.disp_height = SIZE_SAT;
				end
				3: begin
					c.raw_y_low = '1;
					c.raw_y_high = '0;
					c.raw_x_low = RAW_W'(3000);
					c.raw_x_high = RAW_W'(1000);
					c.debounce_ms = '1;
				end
				4: begin
					c.raw_y_high = c.raw_y_low;
					c.raw_x_high = c.raw_x_low;
					c.min_pressure = PRES_W'(PRESSURE_CEIL - 1);
					c.disp_width = '1;
					c.disp_height = '0;
				end
				5: begin
					c.min_pressure = '1;
					c.debounce_ms = '0;
					c.disp_width = SIZE_W'(1);
					c.disp_height = SIZE_W'(1);
				end
				6: begin
					c.raw_y_low = RAW_W'($urandom);
					c.raw_y_high = RAW_W'($urandom);
					c.raw_x_low = RAW_W'($urandom);
					c.raw_x_high = RAW_W'($urandom);
					c.min_pressure = PRES_W'($urandom);
					c.debounce_ms = DEB_W'($urandom);
					c.disp_width = SIZE_W'($urandom);
					c.disp_height = SIZE_W'($urandom);
				end
				default: begin
				end
			endcase
			wait_drained();
			if (ph == 9) begin
				gaps_on = 1'b0;
			end
			load_calibration(c);
			run_gestures(lengths[ph]);
		end
	endtask

	always @(posedge clk) begin
		if (!gaps_on) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_res.point_x = point_x;
			got_res.point_y = point_y;
			got_res.point_pressure = point_pressure;
			got_res.pressed = pressed;
			got_res.tapped = tapped;
			got_res.tap_x = tap_x;
			got_res.tap_y = tap_y;
			got_res.tap_pressure = tap_pressure;
			got_res.tap_valid = tap_valid;
			if (expected_results.size() == 0) begin
				show_mismatch("unexpected result", '0, got_res);
			end else begin
				want_res = expected_results.pop_front();
				if (got_res !== want_res) begin
					show_mismatch("result mismatch", want_res, got_res);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		contact = 1'b0;
		raw_x = '0;
		raw_y = '0;
		raw_pressure = '0;
		now_ms = '0;
		gaps_on = 1'b1;
		clock_ms = 32'd1000;
		cal.raw_y_low = RST_RAW_Y_LOW;
		cal.raw_y_high = RST_RAW_Y_HIGH;
		cal.raw_x_low = RST_RAW_X_LOW;
		cal.raw_x_high = RST_RAW_X_HIGH;
		cal.min_pressure = RST_MIN_PRESSURE;
		cal.debounce_ms = RST_DEBOUNCE_MS;
		cal.disp_width = RST_DISP_WIDTH;
		cal.disp_height = RST_DISP_HEIGHT;
		was_down = 1'b0;
		last_tap_ms = '0;
		hold_x = '0;
		hold_y = '0;
		hold_p = '0;
		hold_valid = 1'b0;
		saved_x = '0;
		saved_y = '0;
		saved_p = '0;
		tap_seen = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_mapping();
		test_calibration_edges();
		test_random_sessions();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (END_WAIT) @(posedge clk);
		if (expected_results.size() != 0) begin
			mismatches += expected_results.size();
			$display("%0d expected results never arrived", expected_results.size());
		end
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### touch_sample_map_and_tap_detect_top.f
+incdir+src
src/tsm_pkg.sv
src/tsm_div.sv
src/tsm_dp.sv
src/tsm_ctrl.sv
src/touch_sample_map_and_tap_detect_top.sv
tb/sv/tb_top.sv
